@@ rtl/grid_path_count_max_sum_macros.svh @@
// Assertion macros for the grid path counter.
`ifndef GRID_PATH_COUNT_MAX_SUM_MACROS_SVH
`define GRID_PATH_COUNT_MAX_SUM_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GPCMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define GPCMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/gpcms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gpcms_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SIZE_W = 7;
	localparam int CODE_W = 2;
	localparam int COUNT_W = 30;
	localparam int BEST_W = 9;
	localparam int DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [COUNT_W:0] PRIME = 31'd1000000007;

	typedef enum logic {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ROW_W-1:0] rows_last;
		logic [COL_W-1:0] cols_last;
		logic             restart;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] count;
		logic [BEST_W-1:0]  best;
	} entry_t;

	function automatic logic [ROW_W-1:0] rows_last_f(logic [SIZE_W-1:0] v);
		int unsigned n;
		n = (v == '0) ? 1 : int'(v);
		if (n > MAX_ROWS) n = MAX_ROWS;
		return ROW_W'(n - 1);
	endfunction

	function automatic logic [COL_W-1:0] cols_last_f(logic [SIZE_W-1:0] v);
		int unsigned n;
		n = (v == '0) ? 1 : int'(v);
		if (n > MAX_COLS) n = MAX_COLS;
		return COL_W'(n - 1);
	endfunction

	function automatic logic [COUNT_W-1:0] add_mod(logic [COUNT_W-1:0] a,
		logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= PRIME) s = s - PRIME;
		return s[COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/gpcms_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface gpcms_in_if import gpcms_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] cell_code;

	modport source (output valid, output cell_code, input ready);
	modport sink (input valid, input cell_code, output ready);
endinterface

interface gpcms_out_if import gpcms_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] path_count;
	logic [BEST_W-1:0]  best_sum;

	modport source (output valid, output path_count, output best_sum, input ready);
	modport sink (input valid, input path_count, input best_sum, output ready);
endinterface

`default_nettype wire

@@ rtl/gpcms_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpcms_cfg import gpcms_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]     pwdata,
	output logic      [DATA_W-1:0]     prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic [SIZE_W-1:0] num_rows_q;
	logic [SIZE_W-1:0] num_cols_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= SIZE_W'(1);
			num_cols_q <= SIZE_W'(1);
		end else if (wr_en) begin
			case (idx)
				REG_NUM_ROWS: num_rows_q <= pwdata[SIZE_W-1:0];
				REG_NUM_COLS: num_cols_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NUM_ROWS: prdata = DATA_W'(num_rows_q);
			REG_NUM_COLS: prdata = DATA_W'(num_cols_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.rows_last = rows_last_f(num_rows_q);
	assign cfg.cols_last = cols_last_f(num_cols_q);
	assign cfg.restart   = wr_en;

endmodule

`default_nettype wire

@@ rtl/grid_path_count_max_sum.sv @@
// Channel    Dir  Payload                      Request
// cell_in    in   cell_code[1:0]               one grid cell, row-major
// result_out out  path_count[29:0], best_sum   one result per grid
// apb        in   num_rows (0x0), num_cols (0x4)
//
// One cell per cycle unless stalled; a cell's row buffer read issues at its accept edge.
// A grid's result is registered in out_valid_q after its last cell leaves stage 1.
// Reset needs no clearing pass; each row is written before the next one reads it.
// A held result stalls the input only while a last cell waits behind it.
`timescale 1ns / 1ps
`default_nettype none

`include "grid_path_count_max_sum_macros.svh"

module grid_path_count_max_sum import gpcms_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	gpcms_in_if.sink                   cell_in,
	gpcms_out_if.source                result_out,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]     pwdata,
	output logic      [DATA_W-1:0]     prdata,
	output logic                       pready
);

	cfg_t cfg;

	gpcms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               accept;
	logic               at_last_row;
	logic               at_last_col;

	logic               valid_s1;
	logic               first_s1;
	logic               has_left_s1;
	logic               has_above_s1;
	logic               last_s1;
	logic [CODE_W-1:0]  code_s1;
	logic [COL_W-1:0]   col_s1;
	entry_t             rd_s1;
	logic               fwd_s1;
	entry_t             fwd_data_s1;

	entry_t             mem [MAX_COLS];
	entry_t             above;
	entry_t             wr_entry;
	logic               mem_we;
	logic               s1_stall;

	logic               left_valid_q;
	logic [COUNT_W-1:0] left_count_q;
	logic [BEST_W-1:0]  left_best_q;

	logic               cur_valid;
	logic [COUNT_W-1:0] cur_count;
	logic [BEST_W-1:0]  cur_best;
	logic [BEST_W-1:0]  cell_best;

	logic               out_valid_q;
	logic [COUNT_W-1:0] path_count_q;
	logic [BEST_W-1:0]  best_sum_q;

	assign s1_stall      = valid_s1 && last_s1 && out_valid_q && !result_out.ready;
	assign cell_in.ready = !s1_stall;
	assign accept        = cell_in.valid && cell_in.ready;
	assign at_last_row   = (row_q == cfg.rows_last);
	assign at_last_col   = (col_q == cfg.cols_last);

	// advance position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg.restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (!s1_stall) valid_s1 <= accept;
			if (accept) fwd_s1 <= mem_we && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1     <= (row_q == '0) && (col_q == '0);
			has_left_s1  <= (col_q != '0);
			has_above_s1 <= (row_q != '0);
			last_s1      <= at_last_row && at_last_col;
			code_s1      <= cell_in.cell_code;
			col_s1       <= col_q;
			fwd_data_s1  <= wr_entry;
		end
	end

	// row buffer: read at accept, write back from stage 1
	always_ff @(posedge clk) begin
		if (mem_we) mem[col_s1] <= wr_entry;
		if (accept) rd_s1 <= mem[col_q];
	end

	assign above = fwd_s1 ? fwd_data_s1 : rd_s1;

	always_comb begin
		cur_valid = 1'b0;
		cur_count = '0;
		cur_best  = '0;
		if (first_s1) begin
			cur_valid = 1'b1;
			cur_count = COUNT_W'(1);
		end else begin
			if (has_left_s1 && left_valid_q) begin
				cur_valid = 1'b1;
				cur_count = left_count_q;
				cur_best  = left_best_q;
			end
			if (has_above_s1 && above.valid) begin
				if (cur_valid) begin
					cur_count = add_mod(cur_count, above.count);
					if (above.best > cur_best) cur_best = above.best;
				end else begin
					cur_valid = 1'b1;
					cur_count = above.count;
					cur_best  = above.best;
				end
			end
		end
	end

	assign cell_best      = cur_best + BEST_W'(code_s1);
	assign mem_we         = valid_s1 && !last_s1;
	assign wr_entry.valid = cur_valid && code_s1[1];
	assign wr_entry.count = cur_count;
	assign wr_entry.best  = cell_best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_valid_q <= 1'b0;
		end else if (cfg.restart) begin
			left_valid_q <= 1'b0;
		end else if (mem_we) begin
			left_valid_q <= cur_valid && code_s1[0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			left_count_q <= cur_count;
			left_best_q  <= cell_best;
		end
	end

	// hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && !s1_stall) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && !s1_stall) begin
			path_count_q <= cur_valid ? cur_count : '0;
			best_sum_q   <= cur_valid ? cell_best : '0;
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.path_count = path_count_q;
	assign result_out.best_sum   = best_sum_q;

	`GPCMS_ASSERT(a_stall_only_last, s1_stall |-> (valid_s1 && last_s1), "stall without last cell")
	`GPCMS_ASSERT_NEXT(a_fwd_on_hit, accept && mem_we && (col_s1 == col_q), fwd_s1, "missed forward")
	`GPCMS_ASSERT(a_col_range, col_q <= cfg.cols_last, "column beyond grid")
	`GPCMS_ASSERT_NEXT(a_result_set, valid_s1 && last_s1 && !s1_stall, out_valid_q, "lost result")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import gpcms_pkg::*;

	localparam logic [CODE_W-1:0] CELL_BLOCK = 2'd0;
	localparam logic [CODE_W-1:0] CELL_RIGHT = 2'd1;
	localparam logic [CODE_W-1:0] CELL_DOWN  = 2'd2;
	localparam logic [CODE_W-1:0] CELL_BOTH  = 2'd3;

	localparam int RANDOM_CELLS   = 600;
	localparam int QUIET_FROM     = 480;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [BEST_W-1:0]  best;
	} grid_result_t;

	typedef struct packed {
		bit                write_cfg;
		logic [SIZE_W-1:0] rows;
		logic [SIZE_W-1:0] cols;
		logic [4:0]        cells;
		logic [15:0]       codes;
		bit                fixed;
		logic [COUNT_W-1:0] count;
		logic [BEST_W-1:0]  best;
	} grid_case_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	gpcms_in_if  cell_if ();
	gpcms_out_if res_if ();

	grid_path_count_max_sum i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_in    (cell_if),
		.result_out (res_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// cells listed first to last from the top bits down
	grid_case_t directed_grids [10] = '{
		'{1'b0, 7'd1, 7'd1, 5'd1, {CELL_BLOCK, 14'd0}, 1'b1, 30'd1, 9'd0},
		'{1'b0, 7'd1, 7'd1, 5'd1, {CELL_BOTH, 14'd0}, 1'b1, 30'd1, 9'd3},
		'{1'b1, 7'd0, 7'd0, 5'd1, {CELL_DOWN, 14'd0}, 1'b1, 30'd1, 9'd2},
		'{1'b1, 7'd1, 7'd2, 5'd2, {CELL_BLOCK, CELL_BOTH, 12'd0}, 1'b1, 30'd0, 9'd0},
		'{1'b1, 7'd2, 7'd2, 5'd4, {CELL_BOTH, CELL_BOTH, CELL_BOTH, CELL_BOTH, 8'd0},
			1'b1, 30'd2, 9'd9},
		'{1'b1, 7'd1, 7'd4, 5'd4, {CELL_RIGHT, CELL_RIGHT, CELL_RIGHT, CELL_BLOCK, 8'd0},
			1'b1, 30'd1, 9'd3},
		'{1'b1, 7'd3, 7'd1, 5'd3, {CELL_DOWN, CELL_DOWN, CELL_RIGHT, 10'd0},
			1'b1, 30'd1, 9'd5},
		'{1'b1, 7'd2, 7'd2, 5'd2, {CELL_BOTH, CELL_BOTH, 12'd0}, 1'b0, 30'd0, 9'd0},
		'{1'b1, 7'd2, 7'd2, 5'd4, {CELL_RIGHT, CELL_DOWN, CELL_BLOCK, CELL_BOTH, 8'd0},
			1'b1, 30'd1, 9'd6},
		'{1'b0, 7'd2, 7'd2, 5'd4, {CELL_BOTH, CELL_RIGHT, CELL_DOWN, CELL_BLOCK, 8'd0},
			1'b1, 30'd0, 9'd0}
	};

	logic [COUNT_W-1:0] up_count [MAX_COLS];
	logic [BEST_W-1:0]  up_best [MAX_COLS];
	bit                 up_ok [MAX_COLS];
	logic [COUNT_W-1:0] left_count;
	logic [BEST_W-1:0]  left_best;
	bit                 left_ok;
	int unsigned        row_at;
	int unsigned        col_at;
	logic [SIZE_W-1:0]  rows_cfg;
	logic [SIZE_W-1:0]  cols_cfg;

	grid_result_t due_results [$];

	int errors;
	int grids_checked;
	int cells_sent;
	int random_cells;
	int stall_cycles;
	int sink_hold;
	bit sender_gaps;
	bit sink_gaps;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned grid_dim(input logic [SIZE_W-1:0] v, input int unsigned lim);
		if (v == '0) return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic void restart_walk();
		row_at = 0;
		col_at = 0;
		left_count = '0;
		left_best = '0;
		left_ok = 1'b0;
	endfunction

	function automatic bit fold_cell(input logic [CODE_W-1:0] code, output grid_result_t res);
		int unsigned nr;
		int unsigned nc;
		int unsigned r;
		int unsigned c;
		bit reach;
		logic [COUNT_W-1:0] cnt;
		logic [BEST_W-1:0] best;
		logic [BEST_W-1:0] here_best;
		logic [COUNT_W:0] sum;
		nr = grid_dim(rows_cfg, MAX_ROWS);
		nc = grid_dim(cols_cfg, MAX_COLS);
		r = row_at;
		c = col_at;
		if (r >= nr || c >= nc) begin
			r = 0;
			c = 0;
		end
		reach = 1'b0;
		cnt = '0;
		best = '0;
		if (r == 0 && c == 0) begin
			reach = 1'b1;
			cnt = COUNT_W'(1);
		end else begin
			if (c > 0 && left_ok) begin
				reach = 1'b1;
				cnt = left_count;
				best = left_best;
			end
			if (r > 0 && up_ok[c]) begin
				if (reach) begin
					sum = {1'b0, cnt} + {1'b0, up_count[c]};
					if (sum >= PRIME) sum = sum - PRIME;
					cnt = sum[COUNT_W-1:0];
					if (up_best[c] > best) best = up_best[c];
				end else begin
					reach = 1'b1;
					cnt = up_count[c];
					best = up_best[c];
				end
			end
		end
		here_best = best + code;
		res = '0;
		if (r == nr - 1 && c == nc - 1) begin
			res.count = reach ? cnt : '0;
			res.best = reach ? here_best : '0;
			restart_walk();
			return 1'b1;
		end
		left_ok = reach && code[0];
		left_count = cnt;
		left_best = here_best;
		up_ok[c] = reach && code[1];
		up_count[c] = cnt;
		up_best[c] = here_best;
		if (c + 1 >= nc) begin
			col_at = 0;
			row_at = r + 1;
			left_ok = 1'b0;
		end else begin
			col_at = c + 1;
			row_at = r;
		end
		return 1'b0;
	endfunction

	function automatic logic [CODE_W-1:0] draw_code(input bit shaped);
		int unsigned roll;
		if (!shaped) return CODE_W'($urandom_range(0, 3));
		roll = $urandom_range(0, 9);
		if (roll < 6) return CELL_BOTH;
		if (roll < 8) return CELL_RIGHT;
		if (roll == 8) return CELL_DOWN;
		return CELL_BLOCK;
	endfunction

	function automatic logic [SIZE_W-1:0] draw_dim();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 13) return SIZE_W'($urandom_range(1, 6));
		if (roll < 17) return SIZE_W'($urandom_range(7, 20));
		if (roll == 17) return '0;
		if (roll == 18) return SIZE_W'(MAX_ROWS);
		return SIZE_W'($urandom_range(65, 127));
	endfunction

	task automatic push_cell(input logic [CODE_W-1:0] code, input bit fixed,
		input grid_result_t fixed_res);
		grid_result_t res;
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			cell_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cell_if.valid <= 1'b1;
		cell_if.cell_code <= code;
		@(posedge clk);
		while (!cell_if.ready) @(posedge clk);
		cells_sent++;
		if (fold_cell(code, res)) due_results.push_back(fixed ? fixed_res : res);
	endtask

	task automatic drain();
		cell_if.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [SIZE_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {25'($urandom()), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_NUM_ROWS) rows_cfg = v;
		else cols_cfg = v;
		restart_walk();
	endtask

	task automatic set_grid(input logic [SIZE_W-1:0] nr, input logic [SIZE_W-1:0] nc);
		drain();
		write_reg(REG_NUM_ROWS, nr);
		write_reg(REG_NUM_COLS, nc);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			sink_hold <= 0;
		end else if (sink_hold != 0) begin
			res_if.ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
			res_if.ready <= 1'b0;
			sink_hold <= $urandom_range(0, 4);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		grid_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: result with nothing due: path_count %0d best_sum %0d",
					$time, res_if.path_count, res_if.best_sum);
				errors++;
			end else begin
				want = due_results.pop_front();
				grids_checked++;
				if (res_if.path_count !== want.count) begin
					$display("%0t: path_count expected %0d got %0d",
						$time, want.count, res_if.path_count);
					errors++;
				end
				if (res_if.best_sum !== want.best) begin
					$display("%0t: best_sum expected %0d got %0d",
						$time, want.best, res_if.best_sum);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		grid_case_t gc;
		logic [SIZE_W-1:0] nr;
		logic [SIZE_W-1:0] nc;
		int unsigned total;
		int unsigned n;
		bit shaped;
		bit must_write;
		arst_n <= 1'b0;
		cell_if.valid <= 1'b0;
		cell_if.cell_code <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sender_gaps = 1'b0;
		sink_gaps = 1'b0;
		for (int i = 0; i < MAX_COLS; i++) begin
			up_count[i] = '0;
			up_best[i] = '0;
			up_ok[i] = 1'b0;
		end
		rows_cfg = SIZE_W'(1);
		cols_cfg = SIZE_W'(1);
		restart_walk();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_grids[i]) begin
			gc = directed_grids[i];
			if (gc.write_cfg) set_grid(gc.rows, gc.cols);
			for (int k = 0; k < gc.cells; k++)
				push_cell(gc.codes[15 - 2 * k -: 2], gc.fixed, '{gc.count, gc.best});
		end

		sender_gaps = 1'b1;
		sink_gaps = 1'b1;
		set_grid(7'd8, 7'd127);
		repeat (8 * MAX_COLS) push_cell(CELL_BOTH, 1'b0, '0);
		set_grid(7'd127, 7'd1);
		repeat (MAX_ROWS) push_cell(draw_code(1'b1), 1'b0, '0);
		set_grid(7'd0, 7'd127);
		repeat (MAX_COLS) push_cell(draw_code(1'b1), 1'b0, '0);
		set_grid(7'd65, 7'd2);
		repeat (2 * MAX_ROWS) push_cell(draw_code(1'b1), 1'b0, '0);

		must_write = 1'b1;
		while (random_cells < RANDOM_CELLS) begin
			if (random_cells >= QUIET_FROM) begin
				sender_gaps = 1'b0;
				sink_gaps = 1'b0;
			end else begin
				sender_gaps = $urandom_range(0, 3) != 0;
				sink_gaps = $urandom_range(0, 3) != 0;
			end
			if (must_write || $urandom_range(0, 2) == 0) begin
				nr = draw_dim();
				nc = draw_dim();
				if (grid_dim(nr, MAX_ROWS) > 20 && grid_dim(nc, MAX_COLS) > 20)
					nc = SIZE_W'($urandom_range(1, 4));
				set_grid(nr, nc);
				must_write = 1'b0;
			end
			total = grid_dim(rows_cfg, MAX_ROWS) * grid_dim(cols_cfg, MAX_COLS);
			n = total;
			// cut the grid short, then restart it through a size write
			if (total > 1 && $urandom_range(0, 11) == 0) begin
				n = $urandom_range(1, total - 1);
				must_write = 1'b1;
			end
			if (n > RANDOM_CELLS - random_cells) begin
				n = RANDOM_CELLS - random_cells;
				must_write = 1'b1;
			end
			shaped = $urandom_range(0, 9) < 7;
			repeat (n) begin
				push_cell(draw_code(shaped), 1'b0, '0);
				random_cells++;
			end
			if (!must_write && $urandom_range(0, 15) == 0) drain();
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Checked %0d grid results over %0d streamed cells, %0d of them random.",
			grids_checked, cells_sent, random_cells);
		$display("Grids ranged from one cell to 64 rows or 64 columns, with clamped sizes,");
		$display("counts past the modulus and restarts.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
